/* rtl/core/ratiometric_current_converter_macros.svh */
// assertion macros for the ratiometric current converter
`ifndef RATIOMETRIC_CURRENT_CONVERTER_MACROS_SVH
`define RATIOMETRIC_CURRENT_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
`define RCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcc same-cycle check failed");
`define RCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcc next-cycle check failed");
`else
`define RCC_ASSERT_IMP(lbl, ante, cons)
`define RCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/rcc_pkg.sv */
// shared types and constants of the ratiometric current converter
package rcc_pkg;

  localparam int RATIO_BITS_DEF = 16;
  localparam int NODE_BITS_DEF  = 20;

  localparam int DIV_BITS      = 16;
  localparam int DIV_FRAC      = 12;
  localparam int GAIN_BITS     = 24;
  localparam int SUP_BITS      = 20;
  localparam int RAT_REG_BITS  = 16;
  localparam int CUR_BITS      = 24;
  localparam int STATUS_BITS   = 3;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK,
    ST_NOT_ZEROED,
    ST_BAD_DIVIDER,
    ST_SUPPLY_RANGE,
    ST_RATIO_RANGE,
    ST_ZERO_REJECTED
  } status_code_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_OUTPUT_DIVIDER,
    REG_SUPPLY_DIVIDER,
    REG_GAIN,
    REG_SUPPLY_MIN,
    REG_SUPPLY_MAX,
    REG_RATIO_MIN,
    REG_RATIO_MAX,
    REG_ZERO_TOLERANCE
  } reg_index_t;

  typedef struct packed {
    logic [DIV_BITS-1:0]     output_divider;
    logic [DIV_BITS-1:0]     supply_divider;
    logic [GAIN_BITS-1:0]    gain_ma_per_ratio;
    logic [SUP_BITS-1:0]     supply_min;
    logic [SUP_BITS-1:0]     supply_max;
    logic [RAT_REG_BITS-1:0] ratio_min;
    logic [RAT_REG_BITS-1:0] ratio_max;
    logic [RAT_REG_BITS-1:0] zero_tolerance;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SUP_DIV,
    S_SUP_CHK,
    S_OUT_DIV,
    S_RAT_CHK,
    S_RAT_DIV,
    S_RAT_WIN,
    S_SCALE,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic         capture;
    logic         div_start_sup;
    logic         div_start_out;
    logic         div_start_rat;
    logic         div_step;
    logic         sup_latch;
    logic         out_latch;
    logic         rat_latch;
    logic         mul;
    logic         scale;
    logic         set_zero;
    logic         set_status;
    logic         keep_data;
    status_code_t status_code;
    logic         out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_set_zero;
    logic zero_ok;
    logic zero_valid;
    logic div_bad;
    logic div_done;
    logic sup_in_window;
    logic outc_lt_sup;
    logic ratio_in_window;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/core/ratiometric_current_converter.sv */
// Ratiometric current converter. Each transaction is one request: a measure
// request corrects both node readings by their dividers, checks the supply
// and ratio windows and returns ratio, supply and current; a set-zero request
// stores the candidate ratio when it lies within tolerance of one half.
// Requests are handled one at a time: a full measurement runs the shared
// restoring divider, which yields one quotient bit per cycle, for the two
// corrections and the ratio, and the next request is accepted only once the
// controller has loaded the result and returned to idle. Requests that fail
// at the first check or set the zero skip the divider. A finished result
// waits in the output register while the next request is accepted; a result
// that cannot be loaded because the output register is still full holds the
// controller.
`include "ratiometric_current_converter_macros.svh"
module ratiometric_current_converter
  import rcc_pkg::*;
#(
  parameter int RATIO_BITS = RATIO_BITS_DEF,
  parameter int NODE_BITS  = NODE_BITS_DEF,
  localparam int IN_TW  = ((2 * NODE_BITS + RATIO_BITS + 7) / 8) * 8,
  localparam int OUT_TW = ((RATIO_BITS + NODE_BITS + CUR_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TW-1:0]         in_tdata,  // output_node, supply_node, zero_candidate
  input  logic                     in_tuser,  // req_type
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TW-1:0]        out_tdata, // ratio_out, supply_level, current_ma
  output logic [STATUS_BITS-1:0]   out_tuser  // status
);

  cfg_t      cfg;
  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  logic [RATIO_BITS-1:0] ratio_out;
  logic [NODE_BITS-1:0]  supply_level;
  logic [CUR_BITS-1:0]   current_ma;

  rcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  rcc_dp #(
    .RATIO_BITS (RATIO_BITS),
    .NODE_BITS  (NODE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (ctrl_cmd),
    .stat           (dp_stat),
    .req_type       (in_tuser),
    .output_node    (in_tdata[NODE_BITS-1:0]),
    .supply_node    (in_tdata[2*NODE_BITS-1:NODE_BITS]),
    .zero_candidate (in_tdata[2*NODE_BITS+RATIO_BITS-1:2*NODE_BITS]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .status         (out_tuser),
    .ratio_out      (ratio_out),
    .supply_level   (supply_level),
    .current_ma     (current_ma)
  );

  assign out_tdata = OUT_TW'({current_ma, supply_level, ratio_out});

  // one request in flight: no second transaction right after acceptance
  `RCC_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  // a result is only loaded when the output register is free
  `RCC_ASSERT_IMP(a_load_when_free, ctrl_cmd.out_load, !out_tvalid || out_tready)
  // the divider is never stepped past its last quotient bit
  `RCC_ASSERT_IMP(a_no_overstep, ctrl_cmd.div_step, !dp_stat.div_done)

endmodule

/* rtl/core/rcc_cfg.sv */
// configuration register file
module rcc_cfg
  import rcc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_divider    <= DIV_BITS'(4096);
      cfg_r.supply_divider    <= DIV_BITS'(4096);
      cfg_r.gain_ma_per_ratio <= '0;
      cfg_r.supply_min        <= SUP_BITS'(72000);
      cfg_r.supply_max        <= SUP_BITS'(88000);
      cfg_r.ratio_min         <= '0;
      cfg_r.ratio_max         <= RAT_REG_BITS'(65535);
      cfg_r.zero_tolerance    <= RAT_REG_BITS'(3277);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_OUTPUT_DIVIDER: cfg_r.output_divider    <= cfg_wdata[DIV_BITS-1:0];
        REG_SUPPLY_DIVIDER: cfg_r.supply_divider    <= cfg_wdata[DIV_BITS-1:0];
        REG_GAIN:           cfg_r.gain_ma_per_ratio <= cfg_wdata[GAIN_BITS-1:0];
        REG_SUPPLY_MIN:     cfg_r.supply_min        <= cfg_wdata[SUP_BITS-1:0];
        REG_SUPPLY_MAX:     cfg_r.supply_max        <= cfg_wdata[SUP_BITS-1:0];
        REG_RATIO_MIN:      cfg_r.ratio_min         <= cfg_wdata[RAT_REG_BITS-1:0];
        REG_RATIO_MAX:      cfg_r.ratio_max         <= cfg_wdata[RAT_REG_BITS-1:0];
        REG_ZERO_TOLERANCE: cfg_r.zero_tolerance    <= cfg_wdata[RAT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/rcc_ctrl.sv */
// sequencing state machine of the converter
module rcc_ctrl
  import rcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.req_set_zero) state_nxt = S_FINISH;
        else if (!stat.zero_valid)      state_nxt = S_FINISH;
        else if (stat.div_bad)          state_nxt = S_FINISH;
        else                            state_nxt = S_SUP_DIV;
      end
      S_SUP_DIV: begin
        if (stat.div_done) state_nxt = S_SUP_CHK;
      end
      S_SUP_CHK: begin
        state_nxt = stat.sup_in_window ? S_OUT_DIV : S_FINISH;
      end
      S_OUT_DIV: begin
        if (stat.div_done) state_nxt = S_RAT_CHK;
      end
      S_RAT_CHK: begin
        state_nxt = stat.outc_lt_sup ? S_RAT_DIV : S_FINISH;
      end
      S_RAT_DIV: begin
        if (stat.div_done) state_nxt = S_RAT_WIN;
      end
      S_RAT_WIN: begin
        state_nxt = stat.ratio_in_window ? S_SCALE : S_FINISH;
      end
      S_SCALE: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_CHECK: begin
        priority if (stat.req_set_zero) begin
          cmd.set_status  = 1'b1;
          cmd.set_zero    = stat.zero_ok;
          cmd.status_code = stat.zero_ok ? ST_OK : ST_ZERO_REJECTED;
        end else if (!stat.zero_valid) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_ZEROED;
        end else if (stat.div_bad) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_BAD_DIVIDER;
        end else begin
          cmd.div_start_sup = 1'b1;
        end
      end
      S_SUP_DIV: begin
        cmd.div_step  = !stat.div_done;
        cmd.sup_latch = stat.div_done;
      end
      S_SUP_CHK: begin
        if (stat.sup_in_window) begin
          cmd.div_start_out = 1'b1;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_SUPPLY_RANGE;
        end
      end
      S_OUT_DIV: begin
        cmd.div_step  = !stat.div_done;
        cmd.out_latch = stat.div_done;
      end
      S_RAT_CHK: begin
        // output at or above supply gives a ratio of one or more
        if (stat.outc_lt_sup) begin
          cmd.div_start_rat = 1'b1;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_RATIO_RANGE;
        end
      end
      S_RAT_DIV: begin
        cmd.div_step  = !stat.div_done;
        cmd.rat_latch = stat.div_done;
      end
      S_RAT_WIN: begin
        if (stat.ratio_in_window) begin
          cmd.mul = 1'b1;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_RATIO_RANGE;
        end
      end
      S_SCALE: begin
        cmd.scale       = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.keep_data   = 1'b1;
        cmd.status_code = ST_OK;
      end
      S_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/rcc_dp.sv */
// datapath: input capture, shared divider, scaling multiplier, result register
module rcc_dp
  import rcc_pkg::*;
#(
  parameter int RATIO_BITS = RATIO_BITS_DEF,
  parameter int NODE_BITS  = NODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  req_type,
  input  logic [NODE_BITS-1:0]  output_node,
  input  logic [NODE_BITS-1:0]  supply_node,
  input  logic [RATIO_BITS-1:0] zero_candidate,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [STATUS_BITS-1:0] status,
  output logic [RATIO_BITS-1:0] ratio_out,
  output logic [NODE_BITS-1:0]  supply_level,
  output logic [CUR_BITS-1:0]   current_ma
);

  localparam int QW = (NODE_BITS > RATIO_BITS) ? NODE_BITS : RATIO_BITS;
  localparam int DW = (NODE_BITS > DIV_BITS) ? NODE_BITS : DIV_BITS;
  localparam int CW = $clog2(QW + 1);
  localparam int SW = (NODE_BITS > SUP_BITS) ? NODE_BITS : SUP_BITS;
  localparam int RW = (RATIO_BITS > RAT_REG_BITS) ? RATIO_BITS : RAT_REG_BITS;
  localparam int PW = RATIO_BITS + 1 + GAIN_BITS;

  // captured item
  logic                  req_r;
  logic [NODE_BITS-1:0]  outn_r, supn_r;
  logic [RATIO_BITS-1:0] cand_r;

  // stored zero
  logic [RATIO_BITS-1:0] zero_r;
  logic                  zero_valid_r;

  // divider
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          sat_r, sat_nxt;

  // intermediate results
  logic [NODE_BITS-1:0]    sup_r, outc_r;
  logic [RATIO_BITS-1:0]   ratio_r;
  logic signed [PW-1:0]    prod_r;
  logic [CUR_BITS-1:0]     cur_r;
  status_code_t            stcode_r;
  logic                    keep_r;

  // output register
  logic                    out_valid_r;
  logic [STATUS_BITS-1:0]  out_status_r;
  logic [RATIO_BITS-1:0]   out_ratio_r;
  logic [NODE_BITS-1:0]    out_sup_r;
  logic [CUR_BITS-1:0]     out_cur_r;

  logic [NODE_BITS-1:0]    corr_node;
  logic [DIV_BITS-1:0]     corr_div;
  logic [DIV_FRAC-1:0]     node_hi;
  logic [NODE_BITS-1:0]    node_lo;
  logic [DW:0]             trial;
  logic                    qbit;
  logic [NODE_BITS-1:0]    corr_res;
  logic [RATIO_BITS-1:0]   half, cand_dist;
  logic signed [RATIO_BITS:0] diff;
  logic signed [PW-1:0]    prod_nxt, q;
  logic [CUR_BITS-1:0]     cur_nxt;
  logic                    q_fits;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_type;
      outn_r <= output_node;
      supn_r <= supply_node;
      cand_r <= zero_candidate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r       <= '0;
      zero_valid_r <= 1'b0;
    end else if (cmd.set_zero) begin
      zero_r       <= cand_r;
      zero_valid_r <= 1'b1;
    end
  end

  // correction divides node * 4096 by the divider; the top bits of the
  // shifted node seed the remainder, saturation when they reach the divider
  always_comb begin
    corr_node = cmd.div_start_out ? outn_r : supn_r;
    corr_div  = cmd.div_start_out ? cfg.output_divider : cfg.supply_divider;
    node_hi   = DIV_FRAC'(corr_node >> (NODE_BITS - DIV_FRAC));
    node_lo   = corr_node << DIV_FRAC;
  end

  always_comb begin
    trial   = {rem_r, quo_r[QW-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    sat_nxt = sat_r;
    priority if (cmd.div_start_sup || cmd.div_start_out) begin
      rem_nxt = DW'(node_hi);
      quo_nxt = QW'(node_lo) << (QW - NODE_BITS);
      den_nxt = DW'(corr_div);
      cnt_nxt = CW'(NODE_BITS);
      sat_nxt = (DIV_BITS'(node_hi) >= corr_div);
    end else if (cmd.div_start_rat) begin
      rem_nxt = DW'(outc_r);
      quo_nxt = '0;
      den_nxt = DW'(sup_r);
      cnt_nxt = CW'(RATIO_BITS);
      sat_nxt = 1'b0;
    end else if (cmd.div_step) begin
      rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], qbit};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    sat_r <= sat_nxt;
  end

  assign corr_res = sat_r ? {NODE_BITS{1'b1}} : quo_r[NODE_BITS-1:0];

  // scaling: floor((ratio - zero) * gain / 2^RATIO_BITS), saturated
  always_comb begin
    diff     = $signed({1'b0, ratio_r}) - $signed({1'b0, zero_r});
    prod_nxt = diff * $signed(cfg.gain_ma_per_ratio);
    q        = prod_r >>> RATIO_BITS;
    q_fits   = (&q[PW-1:CUR_BITS-1]) || !(|q[PW-1:CUR_BITS-1]);
    if (q_fits) begin
      cur_nxt = q[CUR_BITS-1:0];
    end else if (q[PW-1]) begin
      cur_nxt = {1'b1, {(CUR_BITS-1){1'b0}}};
    end else begin
      cur_nxt = {1'b0, {(CUR_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sup_latch) sup_r   <= corr_res;
    if (cmd.out_latch) outc_r  <= corr_res;
    if (cmd.rat_latch) ratio_r <= quo_r[RATIO_BITS-1:0];
    if (cmd.mul)       prod_r  <= prod_nxt;
    if (cmd.scale)     cur_r   <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stcode_r <= ST_OK;
      keep_r   <= 1'b0;
    end else if (cmd.set_status) begin
      stcode_r <= cmd.status_code;
      keep_r   <= cmd.keep_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // failed and set-zero transactions carry zero data
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= stcode_r;
      out_ratio_r  <= keep_r ? ratio_r : '0;
      out_sup_r    <= keep_r ? sup_r : '0;
      out_cur_r    <= keep_r ? cur_r : '0;
    end
  end

  always_comb begin
    half      = RATIO_BITS'(1) << (RATIO_BITS - 1);
    cand_dist = (cand_r >= half) ? (cand_r - half) : (half - cand_r);
  end

  always_comb begin
    stat.req_set_zero    = req_r;
    stat.zero_ok         = (RW'(cand_dist) <= RW'(cfg.zero_tolerance));
    stat.zero_valid      = zero_valid_r;
    stat.div_bad         = (cfg.output_divider == '0) || (cfg.supply_divider == '0);
    stat.div_done        = (cnt_r == '0);
    stat.sup_in_window   = (SW'(sup_r) >= SW'(cfg.supply_min)) &&
                           (SW'(sup_r) <= SW'(cfg.supply_max));
    stat.outc_lt_sup     = (outc_r < sup_r);
    stat.ratio_in_window = (RW'(ratio_r) >= RW'(cfg.ratio_min)) &&
                           (RW'(ratio_r) <= RW'(cfg.ratio_max));
    stat.out_free        = !out_valid_r || out_tready;
  end

  assign out_tvalid   = out_valid_r;
  assign status       = out_status_r;
  assign ratio_out    = out_ratio_r;
  assign supply_level = out_sup_r;
  assign current_ma   = out_cur_r;

endmodule
